>>> rtl/cusc_pkg.sv
// ----------------------------------------------------------------------------
// cusc_pkg
// Shared types and constants of the color unmixing simplex clip unit.
// ----------------------------------------------------------------------------
package cusc_pkg;

   localparam int LAYERS     = 4;
   localparam int CHAN_W     = 16;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = 64;
   localparam int PROD_W     = 33;   // signed 17 x signed 16
   localparam int RAW_W      = 36;   // raw weight, 28 fraction bits, signed
   localparam int NSUM_W     = 37;   // sum of negative weights, signed
   localparam int DEN_W      = 36;   // divisor 2^28 - S, unsigned
   localparam int REM_W      = 49;   // kept weight shifted left by 16
   localparam int QUO_BITS   = 19;   // 18 result bits plus overflow bit
   localparam int DSH_W      = DEN_W + QUO_BITS - 1;
   localparam int WEIGHT_W   = 18;
   localparam int COUNT_W    = 3;

   localparam logic signed [NSUM_W-1:0] ONE_Q28 = NSUM_W'(64'sd268435456);

   typedef enum logic [1:0] {
      REG_ROW_RED   = 2'd0,
      REG_ROW_GREEN = 2'd1,
      REG_ROW_BLUE  = 2'd2,
      REG_ROW_UNIT  = 2'd3
   } reg_index_type;

   // One stage of the shared restoring divider, all four layers side by side
   typedef struct packed {
      logic [DSH_W-1:0]                   dshift;
      logic [COUNT_W-1:0]                 count;
      logic [LAYERS-1:0][REM_W-1:0]       rem;
      logic [LAYERS-1:0][QUO_BITS-1:0]    quo;
   } div_stage_type;

   // Signed Q3.12 coefficient of layer j from a packed row
   function automatic logic signed [COEF_W-1:0] coef_of(
      input logic [ROW_W-1:0] row, input int j);
      coef_of = signed'(row[COEF_W*j +: COEF_W]);
   endfunction

endpackage

>>> rtl/cusc_div_step.sv
// ----------------------------------------------------------------------------
// cusc_div_step
// One quotient bit of the four-lane restoring divider, registered.
// ----------------------------------------------------------------------------
module cusc_div_step
   import cusc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  div_stage_type in_stage,
   output logic          out_valid,
   output div_stage_type out_stage
);

   logic          valid_ff;
   div_stage_type stage_ff, stage_in;

   always_comb begin
      logic ge;
      stage_in        = in_stage;
      stage_in.dshift = in_stage.dshift >> 1;
      for (int j = 0; j < LAYERS; j++) begin
         ge = (DSH_W'(in_stage.rem[j]) >= in_stage.dshift);
         if (ge) begin
            stage_in.rem[j] = REM_W'(DSH_W'(in_stage.rem[j]) - in_stage.dshift);
         end
         stage_in.quo[j] = {in_stage.quo[j][QUO_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

>>> rtl/color_unmix_simplex_clip_unit.sv
// ----------------------------------------------------------------------------
// color_unmix_simplex_clip_unit
// Unmix one RGB pixel into four layer weights and clip them to the simplex.
// ----------------------------------------------------------------------------
// Stages in order: products, raw weights, clip and divisor, divider chain, output register.
// Throughput: one transaction per cycle unless the response stalls; the
//    19-stage divider chain (one quotient bit per stage, four lanes) sets the depth.
// A stalled response holds the whole pipeline; nothing is dropped.
// Reset: synchronous, active high; clears all valid bits and the matrix rows.
// ----------------------------------------------------------------------------
module color_unmix_simplex_clip_unit
   import cusc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WEIGHT_W-1:0] rsp_weight_zero,
   output logic [WEIGHT_W-1:0] rsp_weight_one,
   output logic [WEIGHT_W-1:0] rsp_weight_two,
   output logic [WEIGHT_W-1:0] rsp_weight_three,
   output logic [COUNT_W-1:0]  rsp_negative_count,
   // configuration
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [ROW_W-1:0]    csr_write_data
);

   // Whole pipeline moves together; it holds only when the response is stuck.
   logic advance;

   // ---------------------------------------------------------------- matrix
   logic [ROW_W-1:0] row_red_ff, row_green_ff, row_blue_ff, row_unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_red_ff   <= '0;
         row_green_ff <= '0;
         row_blue_ff  <= '0;
         row_unit_ff  <= '0;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_ROW_RED:   row_red_ff   <= csr_write_data;
            REG_ROW_GREEN: row_green_ff <= csr_write_data;
            REG_ROW_BLUE:  row_blue_ff  <= csr_write_data;
            REG_ROW_UNIT:  row_unit_ff  <= csr_write_data;
            default:       ;
         endcase
      end
   end

   // ---------------------------------------------------- stage 1: products
   // Twelve channel-by-coefficient products; the unit offset just rides along.
   logic                                  s1_valid_ff;
   logic signed [PROD_W-1:0]              prod_red_ff   [LAYERS];
   logic signed [PROD_W-1:0]              prod_green_ff [LAYERS];
   logic signed [PROD_W-1:0]              prod_blue_ff  [LAYERS];
   logic signed [COEF_W-1:0]              unit_ff       [LAYERS];
   logic signed [CHAN_W:0]                red_s, green_s, blue_s;

   assign red_s   = signed'({1'b0, req_red});
   assign green_s = signed'({1'b0, req_green});
   assign blue_s  = signed'({1'b0, req_blue});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < LAYERS; j++) begin
            prod_red_ff[j]   <= red_s   * coef_of(row_red_ff, j);
            prod_green_ff[j] <= green_s * coef_of(row_green_ff, j);
            prod_blue_ff[j]  <= blue_s  * coef_of(row_blue_ff, j);
            unit_ff[j]       <= coef_of(row_unit_ff, j);
         end
      end
   end

   // --------------------------------------------------- stage 2: raw weights
   // Exact weights with 28 fraction bits.
   logic                     s2_valid_ff;
   logic signed [RAW_W-1:0]  raw_ff [LAYERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < LAYERS; j++) begin
            raw_ff[j] <= RAW_W'(prod_red_ff[j]) + RAW_W'(prod_green_ff[j])
                       + RAW_W'(prod_blue_ff[j])
                       + signed'({{(RAW_W-COEF_W-16){unit_ff[j][COEF_W-1]}},
                                  unit_ff[j], 16'h0000});
         end
      end
   end

   // ------------------------------------------- stage 3: clip and divisor
   // Sum the negative weights, form the divisor 2^28 - S, and load the
   // divider with each kept weight shifted left by 16. Dropped weights
   // enter as zero so they fall out as zero.
   logic                                    s3_valid_ff;
   div_stage_type                           s3_stage_ff, s3_stage_in;
   logic [LAYERS-1:0]                       neg;
   logic signed [NSUM_W-1:0]                neg_sum;
   logic [DEN_W-1:0]                        denom;

   always_comb begin
      neg_sum = '0;
      for (int j = 0; j < LAYERS; j++) begin
         neg[j] = raw_ff[j][RAW_W-1];
         if (neg[j]) begin
            neg_sum = neg_sum + NSUM_W'(raw_ff[j]);
         end
      end
      denom = DEN_W'(ONE_Q28 - neg_sum);
      s3_stage_in.dshift = {denom, (QUO_BITS-1)'(0)};
      s3_stage_in.count  = COUNT_W'({2'b00, neg[0]}) + COUNT_W'({2'b00, neg[1]})
                         + COUNT_W'({2'b00, neg[2]}) + COUNT_W'({2'b00, neg[3]});
      for (int j = 0; j < LAYERS; j++) begin
         s3_stage_in.quo[j] = '0;
         if (neg[j]) begin
            s3_stage_in.rem[j] = '0;
         end else begin
            s3_stage_in.rem[j] = {raw_ff[j][REM_W-17:0], 16'h0000};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_stage_ff <= s3_stage_in;
      end
   end

   // ------------------------------------------------------- divider chain
   // First step tests for a quotient of 2^18 or more (saturation); the
   // remaining eighteen steps produce the result bits, most significant first.
   logic          div_valid [QUO_BITS+1];
   div_stage_type div_stage [QUO_BITS+1];

   assign div_valid[0] = s3_valid_ff;
   assign div_stage[0] = s3_stage_ff;

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      cusc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (div_valid[k]),
         .in_stage  (div_stage[k]),
         .out_valid (div_valid[k+1]),
         .out_stage (div_stage[k+1])
      );
   end

   // ------------------------------------------------------ output register
   logic                               rsp_valid_ff;
   logic [LAYERS-1:0][WEIGHT_W-1:0]    weight_ff, weight_in;
   logic [COUNT_W-1:0]                 count_ff;

   always_comb begin
      for (int j = 0; j < LAYERS; j++) begin
         // overflow bit set: saturate
         if (div_stage[QUO_BITS].quo[j][QUO_BITS-1]) begin
            weight_in[j] = '1;
         end else begin
            weight_in[j] = div_stage[QUO_BITS].quo[j][WEIGHT_W-1:0];
         end
      end
   end

   assign advance = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         weight_ff <= weight_in;
         count_ff  <= div_stage[QUO_BITS].count;
      end
   end

   assign req_ready          = advance;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_weight_zero    = weight_ff[0];
   assign rsp_weight_one     = weight_ff[1];
   assign rsp_weight_two     = weight_ff[2];
   assign rsp_weight_three   = weight_ff[3];
   assign rsp_negative_count = count_ff;

`ifndef SYNTHESIS
   // At most four layers can be negative.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (count_ff <= COUNT_W'(LAYERS)))
      else $error("negative count out of range");

   // With every layer clipped, every weight must come out zero.
   a_all_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && count_ff == COUNT_W'(LAYERS)) |-> (weight_ff == '0))
      else $error("nonzero weight with all layers negative");

   // A held pipeline keeps the divider input untouched.
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s3_stage_ff) && $stable(s3_valid_ff)))
      else $error("divider input changed while stalled");
`endif

endmodule

>>> tb/sv/color_unmix_simplex_clip_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_unmix_simplex_clip_unit_tb
// Drives pixels through the unmixing unit under several matrices and random
// handshake stalls, and checks every response against an in-bench predictor
// of the clipped layer weights.
// ----------------------------------------------------------------------------
module color_unmix_simplex_clip_unit_tb;
   import cusc_pkg::*;

   typedef struct packed {
      logic [WEIGHT_W-1:0] w0;
      logic [WEIGHT_W-1:0] w1;
      logic [WEIGHT_W-1:0] w2;
      logic [WEIGHT_W-1:0] w3;
      logic [COUNT_W-1:0]  cnt;
   } weights_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAN_W-1:0]   req_red = '0;
   logic [CHAN_W-1:0]   req_green = '0;
   logic [CHAN_W-1:0]   req_blue = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WEIGHT_W-1:0] rsp_weight_zero;
   logic [WEIGHT_W-1:0] rsp_weight_one;
   logic [WEIGHT_W-1:0] rsp_weight_two;
   logic [WEIGHT_W-1:0] rsp_weight_three;
   logic [COUNT_W-1:0]  rsp_negative_count;
   logic                csr_write_enable = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [ROW_W-1:0]    csr_write_data = '0;

   // predictor copy of the matrix rows
   logic [ROW_W-1:0]    rows [LAYERS];
   weights_type         weights_expected [$];
   int                  errors = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;

   color_unmix_simplex_clip_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic weights_type unmix_clip(input logic [CHAN_W-1:0] r, g, b);
      longint      w [LAYERS];
      longint      nsum;
      longint      q;
      weights_type res;
      logic [WEIGHT_W-1:0] out [LAYERS];
      nsum = 0;
      res.cnt = '0;
      for (int j = 0; j < LAYERS; j++) begin
         w[j] = longint'(r) * longint'(signed'(rows[REG_ROW_RED][16*j +: 16]))
              + longint'(g) * longint'(signed'(rows[REG_ROW_GREEN][16*j +: 16]))
              + longint'(b) * longint'(signed'(rows[REG_ROW_BLUE][16*j +: 16]))
              + longint'(signed'(rows[REG_ROW_UNIT][16*j +: 16])) * 65536;
         if (w[j] < 0) begin
            nsum += w[j];
            res.cnt++;
         end
      end
      for (int j = 0; j < LAYERS; j++) begin
         q = 0;
         if (w[j] > 0) begin
            q = (w[j] << 16) / ((longint'(1) << 28) - nsum);
            if (q > 262143) q = 262143;
         end
         out[j] = q[WEIGHT_W-1:0];
      end
      res.w0 = out[0]; res.w1 = out[1]; res.w2 = out[2]; res.w3 = out[3];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // Send one pixel; valid stays up until accepted and drops only on idle.
   task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= r; req_green <= g; req_blue <= b;
      do @(posedge clock); while (!req_ready);
      weights_expected.push_back(unmix_clip(r, g, b));
   endtask

   // Receiver: random stall, then compare each accepted response.
   always @(posedge clock) begin
      weights_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (weights_expected.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            exp_w = weights_expected.pop_front();
            if (rsp_weight_zero !== exp_w.w0)
               report_mismatch("weight_zero", rsp_weight_zero, exp_w.w0);
            if (rsp_weight_one !== exp_w.w1)
               report_mismatch("weight_one", rsp_weight_one, exp_w.w1);
            if (rsp_weight_two !== exp_w.w2)
               report_mismatch("weight_two", rsp_weight_two, exp_w.w2);
            if (rsp_weight_three !== exp_w.w3)
               report_mismatch("weight_three", rsp_weight_three, exp_w.w3);
            if (rsp_negative_count !== exp_w.cnt)
               report_mismatch("negative_count", rsp_negative_count, exp_w.cnt);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Drain outstanding responses; only then touch the matrix.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (weights_expected.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_row(input reg_index_type idx, input logic [ROW_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      rows[idx] = val;
   endtask

   task automatic load_matrix(input logic [ROW_W-1:0] rr, rg, rb, ru);
      wait_idle();
      write_row(REG_ROW_RED, rr);
      write_row(REG_ROW_GREEN, rg);
      write_row(REG_ROW_BLUE, rb);
      write_row(REG_ROW_UNIT, ru);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [ROW_W-1:0] rand_row();
      return {$urandom, $urandom};
   endfunction

   // four coefficients in -4096..4095
   function automatic logic [ROW_W-1:0] small_row();
      logic [ROW_W-1:0] row;
      for (int j = 0; j < LAYERS; j++)
         row[16*j +: 16] = 16'($urandom_range(8191)) - 16'd4096;
      return row;
   endfunction

   // pack four Q3.12 coefficients
   function automatic logic [ROW_W-1:0] pack4(input logic [15:0] c0, c1, c2, c3);
      return {c3, c2, c1, c0};
   endfunction

   task automatic test_reset_matrix();
      // all-zero matrix: every weight is zero, none negative
      send_pixel(16'hFFFF, 16'h0000, 16'h8000);
      send_pixel(16'h0000, 16'h0000, 16'h0000);
   endtask

   task automatic test_directed();
      // identity-like: layers follow channels, unit layer one minus sum
      load_matrix(pack4(16'h1000, 16'h0000, 16'h0000, 16'hF000),
                  pack4(16'h0000, 16'h1000, 16'h0000, 16'hF000),
                  pack4(16'h0000, 16'h0000, 16'h1000, 16'hF000),
                  pack4(16'h0000, 16'h0000, 16'h0000, 16'h1000));
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);   // negative last layer
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'h8000, 16'h4000, 16'h0001);
      send_pixel(16'h0000, 16'h8000, 16'h8000);   // exact zero weight
      // extreme coefficients: large weights saturate
      load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                  64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      // all negative
      load_matrix(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                  64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      // mixed signs: some clipped, others rescaled
      load_matrix(pack4(16'h7FFF, 16'h8000, 16'h1000, 16'hF000),
                  pack4(16'h8000, 16'h7FFF, 16'h0800, 16'h0000),
                  pack4(16'h1000, 16'h8000, 16'h7FFF, 16'hFFFF),
                  pack4(16'h0000, 16'h0001, 16'hFFFF, 16'h2000));
      send_pixel(16'hFFFF, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'h0000, 16'hFFFF);
      send_pixel(16'h5555, 16'hAAAA, 16'h1234);
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            // mostly small coefficients so that weights fall in range
            if ($urandom_range(3) == 0)
               load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
            else
               load_matrix(small_row(), small_row(), small_row(), small_row());
         end
         send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      for (int j = 0; j < LAYERS; j++) rows[j] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 36; recv_idle_pct = 52;
      test_reset_matrix();
      test_directed();
      test_random(330);
      send_idle_pct = 52; recv_idle_pct = 36;
      test_random(330);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(340);
      wait_idle();
      if (errors == 0) $display("[color_unmix_simplex_clip_unit] OK");
      else $display("[color_unmix_simplex_clip_unit] ERROR");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("[color_unmix_simplex_clip_unit] ERROR");
      $finish;
   end

endmodule
